FILE: hw/rtl/btf_pkg.sv
// Shared types and constants for the branch trace text formatter.
// No dependencies; used by every module of the block.
package btf_pkg;

    localparam int unsigned AddrWidth = 32;
    localparam int unsigned CharWidth = 8;
    localparam int unsigned RunLen    = 32;
    localparam int unsigned LineLen   = 16;
    localparam int unsigned IdxWidth  = $clog2(RunLen);
    localparam int unsigned TextWidth = RunLen * CharWidth;

    // Decoded branch, passed from the decode stage to the format stage
    typedef struct packed {
        logic [AddrWidth-1:0] addr;
        logic [AddrWidth-1:0] target;
        logic                 link;
        logic [3:0]           cond;
    } dec_t;

    // One formatted run; character k sits at bits [8k +: 8]
    typedef logic [TextWidth-1:0] text_t;

endpackage

FILE: hw/rtl/btf_decode.sv
// Decode stage: branch detection and target address computation.
// Depends on btf_pkg.
module btf_decode (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [btf_pkg::AddrWidth-1:0]    in_addr,
    input  logic [btf_pkg::AddrWidth-1:0]    in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output btf_pkg::dec_t                    out_dec
);

    logic                                 valid_reg;
    logic                                 valid_next;
    btf_pkg::dec_t                        dec_reg;
    btf_pkg::dec_t                        dec_next;
    logic                                 is_branch;
    logic [btf_pkg::AddrWidth-1:0]        offset;

    // Advance when the stage is empty or its request moves on
    assign in_ready  = !valid_reg || out_ready;
    assign is_branch = (in_word[27:25] == 3'b101);

    // Sign-extend the 24-bit word offset and scale it to bytes
    assign offset = {{6{in_word[23]}}, in_word[23:0], 2'b00};

    always_comb begin
        valid_next = valid_reg;
        dec_next   = dec_reg;
        if (in_ready) begin
            // drop non-branch requests right here
            valid_next = in_valid && is_branch;
        end
        if (in_valid && in_ready) begin
            dec_next.addr   = in_addr;
            dec_next.target = in_addr + 32'd8 + offset;
            dec_next.link   = in_word[24];
            dec_next.cond   = in_word[31:28];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        dec_reg <= dec_next;
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

endmodule

FILE: hw/rtl/btf_format.sv
// Format stage: builds the 32 ASCII characters of one branch run.
// Depends on btf_pkg.
module btf_format (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  btf_pkg::dec_t  in_dec,
    output logic           out_valid,
    input  logic           out_ready,
    output btf_pkg::text_t out_text
);

    // Condition mnemonics, first letter in the upper byte
    localparam logic [15:0] CondText [16] = '{
        "EQ", "NE", "CS", "CC", "MI", "PL", "VS", "VC",
        "HI", "LS", "GE", "LT", "GT", "LE", "  ", "TH"
    };

    localparam logic [7:0] Space = " ";

    logic           valid_reg;
    logic           valid_next;
    btf_pkg::text_t text_reg;
    btf_pkg::text_t text_next;
    btf_pkg::text_t text;

    // Uppercase hex digit of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        return (nib <= 4'd9) ? wide + 8'd48 : wide + 8'd55;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    // Lay out both lines of text
    always_comb begin
        text = '0;
        text[0*8 +: 8]  = Space;
        text[1*8 +: 8]  = Space;
        text[2*8 +: 8]  = "A";
        text[3*8 +: 8]  = "D";
        text[4*8 +: 8]  = "D";
        text[5*8 +: 8]  = "R";
        text[6*8 +: 8]  = "=";
        for (int k = 0; k < 8; k++) begin
            text[(7 + k)*8 +: 8]  = hex_char(in_dec.addr[(28 - 4*k) +: 4]);
            text[(23 + k)*8 +: 8] = hex_char(in_dec.target[(28 - 4*k) +: 4]);
        end
        text[15*8 +: 8] = Space;
        text[16*8 +: 8] = Space;
        text[17*8 +: 8] = Space;
        text[18*8 +: 8] = in_dec.link ? "B" : Space;
        text[19*8 +: 8] = in_dec.link ? "L" : "B";
        text[20*8 +: 8] = CondText[in_dec.cond][15:8];
        text[21*8 +: 8] = CondText[in_dec.cond][7:0];
        text[22*8 +: 8] = Space;
        text[31*8 +: 8] = Space;
    end

    always_comb begin
        valid_next = valid_reg;
        text_next  = text_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (in_valid && in_ready) begin
            text_next = text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        text_reg <= text_next;
    end

    assign out_valid = valid_reg;
    assign out_text  = text_reg;

endmodule

FILE: hw/rtl/btf_serial.sv
// Output stage: shifts a formatted run out one character per request.
// Depends on btf_pkg.
module btf_serial (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  btf_pkg::text_t                  in_text,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [btf_pkg::CharWidth-1:0]   m_char_code,
    output logic                            m_line_select,
    output logic                            m_last_char
);

    localparam logic [btf_pkg::IdxWidth-1:0] LastIdx = btf_pkg::IdxWidth'(btf_pkg::RunLen - 1);

    logic                            valid_reg;
    logic                            valid_next;
    btf_pkg::text_t                  text_reg;
    btf_pkg::text_t                  text_next;
    logic [btf_pkg::IdxWidth-1:0]    idx_reg;
    logic [btf_pkg::IdxWidth-1:0]    idx_next;
    logic                            take;
    logic                            take_last;

    assign take      = valid_reg && m_ready;
    assign take_last = take && (idx_reg == LastIdx);

    // Load a new run as the last character of the current one leaves
    assign in_ready = !valid_reg || take_last;

    always_comb begin
        valid_next = valid_reg;
        text_next  = text_reg;
        idx_next   = idx_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                text_next = in_text;
                idx_next  = '0;
            end
        end else if (take) begin
            // advance to the next character
            text_next = text_reg >> btf_pkg::CharWidth;
            idx_next  = idx_reg + btf_pkg::IdxWidth'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
        text_reg <= text_next;
    end

    assign m_valid       = valid_reg;
    assign m_char_code   = text_reg[btf_pkg::CharWidth-1:0];
    assign m_line_select = idx_reg[btf_pkg::IdxWidth-1];
    assign m_last_char   = (idx_reg == LastIdx);

endmodule

FILE: hw/rtl/branch_trace_text_formatter.sv
// Branch trace text formatter: top level tying decode, format and output stages.
// Depends on btf_pkg, btf_decode, btf_format and btf_serial.
//
// Takes one (address, ARM instruction word) request per cycle while s_ready is
// high. Words whose bits 27:25 are not 101 are dropped in the decode stage. Each
// branch passes decode (target add) and format (ASCII layout) stages, then the
// output stage sends its 32 characters, one per cycle while m_ready is high:
// "  ADDR=hhhhhhhh " and "  BLcc hhhhhhhh " (or " B"), uppercase hex, line_select
// marking the second line and last_char the 32nd character. The first character
// is offered once the request has passed the decode, format and output registers.
// The output shift register holds one run and takes the next only as the last
// character of the current one leaves; up to two more branches wait in the
// decode and format stages while it drains.
module branch_trace_text_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instr_address,
    input  logic [31:0] s_instr_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_code,
    output logic        m_line_select,
    output logic        m_last_char
);

    logic           dec_valid;
    logic           dec_ready;
    btf_pkg::dec_t  dec;
    logic           fmt_valid;
    logic           fmt_ready;
    btf_pkg::text_t fmt_text;

    btf_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_addr   (s_instr_address),
        .in_word   (s_instr_word),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_dec   (dec)
    );

    btf_format u_format (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_dec    (dec),
        .out_valid (fmt_valid),
        .out_ready (fmt_ready),
        .out_text  (fmt_text)
    );

    btf_serial u_serial (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (fmt_valid),
        .in_ready      (fmt_ready),
        .in_text       (fmt_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_line_select (m_line_select),
        .m_last_char   (m_last_char)
    );

`ifndef NO_ASSERTIONS
    // The final character always belongs to the branch line
    a_last_on_line1: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_char) |-> m_line_select)
        else $error("last character outside the branch line");

    // A run never stops before its last character
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_char) |=> m_valid)
        else $error("run ended early");

    // A new run opens on the address line with a space
    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_char) |=>
            (!m_valid || (!m_line_select && !m_last_char && m_char_code == 8'h20)))
        else $error("run did not restart at its first character");
`endif

endmodule

FILE: tb/sv/tb_branch_trace_text_formatter.sv
// Self-checking testbench for branch_trace_text_formatter: directed table, then random
// trace pairs, with an in-bench text predictor and a per-character scoreboard.
// Depends on btf_pkg and the branch_trace_text_formatter RTL.
module tb_branch_trace_text_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TextBits        = btf_pkg::RunLen * btf_pkg::CharWidth;
    localparam int unsigned RandomRequests  = 125;
    localparam int unsigned IdlePercent     = 28;
    localparam int unsigned DropPercent     = 25;
    localparam int unsigned HoldStart       = 1600;
    localparam int unsigned HoldLen         = 400;
    localparam int unsigned SteadyStart     = 3000;
    localparam int unsigned SteadyLen       = 1000;
    localparam int unsigned DrainCycles     = 16;
    localparam int unsigned LimitCycles     = 200000;
    localparam int unsigned ReportCap       = 200;

    // Condition field of the branch word
    typedef enum logic [3:0] {
        COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
        COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL, COND_NV
    } cond_e;

    // How a directed row gets its expectation
    typedef enum logic [1:0] {
        ROW_DROPPED,
        ROW_TYPED,
        ROW_PREDICTED
    } row_kind_e;

    // Character k of a run sits at bits [TextBits-1-8k -: 8], as in a string literal
    typedef logic [TextBits-1:0] run_text_t;

    typedef struct packed {
        row_kind_e   kind;
        logic [31:0] addr;
        logic [31:0] word;
        run_text_t   text;
    } stim_row_t;

    typedef struct {
        logic [7:0] char_code;
        logic       line_sel;
        logic       last;
    } char_exp_t;

    localparam logic [15:0] COND_TEXT [16] = '{
        "EQ", "NE", "CS", "CC", "MI", "PL", "VS", "VC",
        "HI", "LS", "GE", "LT", "GT", "LE", "  ", "TH"
    };
    localparam logic [55:0] ADDR_TAG = "  ADDR=";

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [31:0] s_instr_address = '0;
    logic [31:0] s_instr_word    = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_char_code;
    logic        m_line_select;
    logic        m_last_char;

    char_exp_t   expected_chars [$];
    stim_row_t   directed_rows [$];
    bit          sender_steady  = 1'b0;
    int unsigned branch_count   = 0;
    int unsigned dropped_count  = 0;
    int unsigned chars_checked  = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    branch_trace_text_formatter u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_instr_address (s_instr_address),
        .s_instr_word    (s_instr_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_code     (m_char_code),
        .m_line_select   (m_line_select),
        .m_last_char     (m_last_char)
    );

    always #1 aclk = ~aclk;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib <= 4'd9) ? "0" + 8'(nib) : "A" - 8'd10 + 8'(nib);
    endfunction

    function automatic logic [31:0] make_branch(input cond_e cond, input logic link,
                                                input logic [23:0] offset);
        return {cond, 3'b101, link, offset};
    endfunction

    function automatic stim_row_t make_row(input row_kind_e kind, input logic [31:0] addr,
                                           input logic [31:0] word, input run_text_t text);
        return '{kind: kind, addr: addr, word: word, text: text};
    endfunction

    // Lay out the two text lines of a branch; return 0 for words that are not branches
    function automatic bit format_branch(input logic [31:0] addr, input logic [31:0] word,
                                         output run_text_t text);
        logic [7:0]  chars [btf_pkg::RunLen];
        logic [31:0] target;
        logic [15:0] cond_pair;
        text = '0;
        if (word[27:25] != 3'b101) begin
            return 1'b0;
        end
        target    = addr + 32'd8 + {{6{word[23]}}, word[23:0], 2'b00};
        cond_pair = COND_TEXT[word[31:28]];
        for (int k = 0; k < 7; k++) begin
            chars[k] = ADDR_TAG[55-8*k -: 8];
        end
        for (int k = 0; k < 8; k++) begin
            chars[7+k]  = hex_char(addr[31-4*k -: 4]);
            chars[23+k] = hex_char(target[31-4*k -: 4]);
        end
        chars[15] = " ";
        chars[16] = " ";
        chars[17] = " ";
        chars[18] = word[24] ? "B" : " ";
        chars[19] = word[24] ? "L" : "B";
        chars[20] = cond_pair[15:8];
        chars[21] = cond_pair[7:0];
        chars[22] = " ";
        chars[31] = " ";
        for (int k = 0; k < btf_pkg::RunLen; k++) begin
            text[TextBits-1-8*k -: 8] = chars[k];
        end
        return 1'b1;
    endfunction

    // Queue the 32 characters of one run
    function automatic void queue_run(input run_text_t text);
        for (int k = 0; k < btf_pkg::RunLen; k++) begin
            expected_chars.push_back('{char_code: text[TextBits-1-8*k -: 8],
                                       line_sel:  (k >= btf_pkg::LineLen),
                                       last:      (k == btf_pkg::RunLen - 1)});
        end
        branch_count++;
    endfunction

    function automatic void predict_request(input logic [31:0] addr, input logic [31:0] word);
        run_text_t text;
        if (format_branch(addr, word, text)) begin
            queue_run(text);
        end else begin
            dropped_count++;
        end
    endfunction

    // Offer one request, idling first at random, and return once it is taken
    task automatic send_request(input logic [31:0] addr, input logic [31:0] word);
        while (!sender_steady && $urandom_range(99) < IdlePercent) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_instr_address <= addr;
        s_instr_word    <= word;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] random_address();
        case ($urandom_range(7))
            0:       return 32'($urandom_range(255));
            1:       return 32'hFFFF_FFFF - 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off, one stretch always ready
    initial begin
        int unsigned rx_cycles;
        rx_cycles = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            rx_cycles++;
            if (rx_cycles >= HoldStart && rx_cycles < HoldStart + HoldLen) begin
                m_ready <= 1'b0;
            end else if (rx_cycles >= SteadyStart && rx_cycles < SteadyStart + SteadyLen) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IdlePercent);
            end
        end
    end

    // Compare each delivered character with the oldest expectation
    always @(posedge aclk) begin : check_output
        char_exp_t head;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                if (mismatches < ReportCap) begin
                    $display("%0t: unexpected character: expected none, actual %h line %b last %b",
                             $time, m_char_code, m_line_select, m_last_char);
                end
                mismatches++;
            end else begin
                head = expected_chars.pop_front();
                chars_checked++;
                if (m_char_code !== head.char_code || m_line_select !== head.line_sel ||
                    m_last_char !== head.last) begin
                    if (mismatches < ReportCap) begin
                        $display({"%0t: expected char %h line %b last %b, ",
                                  "actual char %h line %b last %b"},
                                 $time, head.char_code, head.line_sel, head.last,
                                 m_char_code, m_line_select, m_last_char);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LimitCycles) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d characters outstanding",
                 cycle_count, expected_chars.size());
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        stim_row_t   row;
        logic [31:0] addr;
        logic [31:0] word;
        int unsigned sent;

        // Directed rows: extremes, condition letters, sign bit, wrap, near-miss words
        directed_rows.push_back(make_row(ROW_TYPED, 32'h0000_0000,
            make_branch(COND_AL, 1'b0, 24'h000000), "  ADDR=00000000    B   00000008 "));
        directed_rows.push_back(make_row(ROW_TYPED, 32'hFFFF_FFFF,
            make_branch(COND_AL, 1'b1, 24'hFFFFFF), "  ADDR=FFFFFFFF   BL   00000003 "));
        directed_rows.push_back(make_row(ROW_DROPPED, 32'h0000_0000, 32'h0000_0000, '0));
        directed_rows.push_back(make_row(ROW_DROPPED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
        directed_rows.push_back(make_row(ROW_TYPED, 32'h0000_1000,
            make_branch(COND_NV, 1'b0, 24'h000000), "  ADDR=00001000    BTH 00001008 "));
        directed_rows.push_back(make_row(ROW_TYPED, 32'h0000_0000,
            make_branch(COND_EQ, 1'b0, 24'h080000), "  ADDR=00000000    BEQ 00200008 "));
        directed_rows.push_back(make_row(ROW_PREDICTED, 32'h1234_5678,
            make_branch(COND_NE, 1'b1, 24'h800000), '0));
        directed_rows.push_back(make_row(ROW_PREDICTED, 32'hFFFF_FFF0,
            make_branch(COND_GT, 1'b0, 24'h7FFFFF), '0));
        directed_rows.push_back(make_row(ROW_DROPPED, 32'h0000_0100, 32'h0C00_0000, '0));
        directed_rows.push_back(make_row(ROW_DROPPED, 32'h0000_0104, 32'h0800_0000, '0));
        directed_rows.push_back(make_row(ROW_DROPPED, 32'h0000_0108, 32'hF4FF_FFFF, '0));
        for (int c = int'(COND_EQ); c <= int'(COND_LE); c++) begin
            directed_rows.push_back(make_row(ROW_PREDICTED, $urandom,
                make_branch(cond_e'(c), c[0], 24'($urandom)), '0));
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.addr, row.word);
            case (row.kind)
                ROW_TYPED:   queue_run(row.text);
                ROW_DROPPED: dropped_count++;
                default:     predict_request(row.addr, row.word);
            endcase
        end

        // Random part: mostly branches with random content, some dropped words
        sent = 0;
        while (sent < RandomRequests) begin
            sender_steady = (sent >= 40 && sent < 80);
            addr = random_address();
            word = $urandom;
            if ($urandom_range(99) < DropPercent) begin
                while (word[27:25] == 3'b101) begin
                    word[27:25] = 3'($urandom_range(7));
                end
            end else begin
                word[27:25] = 3'b101;
                case ($urandom_range(7))
                    0:       word[23:0] = 24'h7FFFFF;
                    1:       word[23:0] = 24'h800000;
                    default: ;
                endcase
            end
            sent++;
            send_request(addr, word);
            predict_request(addr, word);
        end
        s_valid <= 1'b0;

        // Drain
        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);

        $display("Covered %0d branch requests and %0d dropped words in %0d cycles;",
                 branch_count, dropped_count, cycle_count);
        $display("compared %0d characters, %0d mismatches.", chars_checked, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
